// ----- rtl/rped_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rped_pkg: shared types and constants
// Status codes, sequencer states and datapath widths for the exponent unit.
// ----------------------------------------------------------------------------
package rped_pkg;

    localparam int WORD_W = 32;
    localparam int CAND_W = 16;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_PRIME = 2'd1,
        ST_NO_INV    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PR_TEST,
        S_PR_DIV,
        S_PR_NEXT,
        S_PHI,
        S_EU_INIT,
        S_EU_GO,
        S_EU_DIV,
        S_EU_MUL,
        S_FIN
    } state_t;

    // handshake between the sequencer and a serial unit
    typedef struct packed {
        logic start;
    } unit_req_t;

    typedef struct packed {
        logic done;
    } unit_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/rped_serial_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rped_serial_div: restoring divider
// One quotient bit per cycle; quotient and remainder valid with done.
// ----------------------------------------------------------------------------
module rped_serial_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rped_pkg::unit_req_t           req,
    input  wire logic [rped_pkg::WORD_W-1:0]   dividend,
    input  wire logic [rped_pkg::WORD_W-1:0]   divisor,
    output rped_pkg::unit_rsp_t                rsp,
    output logic      [rped_pkg::WORD_W-1:0]   quotient,
    output logic      [rped_pkg::WORD_W-1:0]   remainder
);
    logic [rped_pkg::WORD_W-1:0] quo_reg, quo_next;
    logic [rped_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [rped_pkg::WORD_W-1:0] dvs_reg;
    logic [rped_pkg::CNT_W-1:0]  cnt_reg;
    logic                        busy_reg, done_reg;
    logic [rped_pkg::WORD_W:0]   trial;

    always_comb begin
        trial = {rem_reg, quo_reg[rped_pkg::WORD_W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = rped_pkg::WORD_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[rped_pkg::WORD_W-2:0], 1'b1};
        end else begin
            rem_next = trial[rped_pkg::WORD_W-1:0];
            quo_next = {quo_reg[rped_pkg::WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '1);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- rtl/rped_serial_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rped_serial_mulmod: modular multiply, MSB-first double and add
// Gives k * c mod m for any 32-bit k, with c < m; one bit of k per cycle.
// ----------------------------------------------------------------------------
module rped_serial_mulmod (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rped_pkg::unit_req_t           req,
    input  wire logic [rped_pkg::WORD_W-1:0]   mult,
    input  wire logic [rped_pkg::WORD_W-1:0]   mcand,
    input  wire logic [rped_pkg::WORD_W-1:0]   modulus,
    output rped_pkg::unit_rsp_t                rsp,
    output logic      [rped_pkg::WORD_W-1:0]   product
);
    logic [rped_pkg::WORD_W-1:0] k_reg, c_reg, m_reg, acc_reg, acc_next;
    logic [rped_pkg::CNT_W-1:0]  cnt_reg;
    logic                        busy_reg, done_reg;
    logic [rped_pkg::WORD_W:0]   dbl, dbl_red, sum;

    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red + {1'b0, c_reg};
        if (k_reg[rped_pkg::WORD_W-1]) begin
            acc_next = (sum >= {1'b0, m_reg}) ? rped_pkg::WORD_W'(sum - {1'b0, m_reg})
                                              : sum[rped_pkg::WORD_W-1:0];
        end else begin
            acc_next = dbl_red[rped_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '1);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            k_reg   <= mult;
            c_reg   <= mcand;
            m_reg   <= modulus;
            acc_reg <= '0;
        end else if (busy_reg) begin
            k_reg   <= {k_reg[rped_pkg::WORD_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign product  = acc_reg;

endmodule
`default_nettype wire

// ----- rtl/rsa_private_exponent_derive_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_private_exponent_derive_unit: RSA private exponent from p, q, e
// Trial-division prime check of p and q, phi = (p-1)(q-1), then extended
// Euclid on (phi, e) with coefficients kept mod phi.
//
//  channel | ports                                    | dir | per beat
//  s_      | s_prime_p, s_prime_q, s_public_exponent  | in  | one key request
//  m_      | m_private_exponent, m_status             | out | one result
//
// - One request at a time. Each trial divisor costs one pass of the shared
//   serial divider; each Euclid step costs a divider pass plus a serial
//   mod-multiply pass, and the last step costs only a divider pass.
// - Reset: aresetn synchronous, active low; clears sequencer and valids.
// - A result beat held by m_ready low blocks the next request from finishing,
//   not its computation; s_ready is high whenever the sequencer is idle.
// ----------------------------------------------------------------------------
module rsa_private_exponent_derive_unit #(
    parameter int PRIME_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_prime_p,
    input  wire logic [15:0] s_prime_q,
    input  wire logic [31:0] s_public_exponent,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_private_exponent,
    output logic [1:0]       m_status
);
    localparam int W  = rped_pkg::WORD_W;
    localparam int CW = rped_pkg::CAND_W;
    // candidates only use the low PRIME_WIDTH bits of the 16-bit ports
    localparam int EFF_W = (PRIME_WIDTH < CW) ? PRIME_WIDTH : CW;
    localparam logic [CW-1:0] CAND_MASK = CW'((64'd1 << EFF_W) - 64'd1);

    rped_pkg::state_t state_reg, state_next;

    // request operands
    logic [CW-1:0] p_reg, p_next, q_reg, q_next;
    logic [W-1:0]  e_reg, e_next;

    // trial division: n under test, divisor i, and i*i kept incrementally
    logic [CW-1:0] n_reg, n_next;
    logic [8:0]    i_reg, i_next;
    logic [16:0]   sq_reg, sq_next;
    logic          which_reg, which_next;

    // Euclid registers
    logic [W-1:0]  phi_reg, phi_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [W-1:0]  c0_reg, c0_next, c1_reg, c1_next;
    logic [W-1:0]  quo_reg, quo_next, r_reg, r_next;

    // pending result and output register
    logic [W-1:0]  res_d_reg, res_d_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          m_valid_reg, m_valid_next;
    logic [W-1:0]  m_d_reg, m_d_next;
    logic [1:0]    m_st_reg, m_st_next;

    rped_pkg::unit_req_t div_req, mul_req;
    rped_pkg::unit_rsp_t div_rsp, mul_rsp;
    logic [W-1:0]  div_dividend, div_divisor, div_quo, div_rem;
    logic [W-1:0]  mul_prod;
    logic [W:0]    cn_wide;
    logic          mul_kick_reg;

    rped_serial_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .rsp       (div_rsp),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rped_serial_mulmod u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .mult    (quo_reg),
        .mcand   (c1_reg),
        .modulus (phi_reg),
        .rsp     (mul_rsp),
        .product (mul_prod)
    );

    // divider operands: trial division while checking primes, else Euclid
    always_comb begin
        if (state_reg == rped_pkg::S_PR_TEST || state_reg == rped_pkg::S_PR_DIV) begin
            div_dividend = W'(n_reg);
            div_divisor  = W'(i_reg);
        end else begin
            div_dividend = a_reg;
            div_divisor  = b_reg;
        end
    end

    // c0 - q*c1 mod phi
    assign cn_wide = (c0_reg >= mul_prod) ? {1'b0, c0_reg} - {1'b0, mul_prod}
                                          : {1'b0, c0_reg} + {1'b0, phi_reg} - {1'b0, mul_prod};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rped_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg      <= p_next;
        q_reg      <= q_next;
        e_reg      <= e_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        sq_reg     <= sq_next;
        which_reg  <= which_next;
        phi_reg    <= phi_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        quo_reg    <= quo_next;
        r_reg      <= r_next;
        res_d_reg  <= res_d_next;
        res_st_reg <= res_st_next;
        m_d_reg    <= m_d_next;
        m_st_reg   <= m_st_next;
    end

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        e_next       = e_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        which_next   = which_reg;
        phi_next     = phi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c0_next      = c0_reg;
        c1_next      = c1_reg;
        quo_next     = quo_reg;
        r_next       = r_reg;
        res_d_next   = res_d_reg;
        res_st_next  = res_st_reg;
        m_d_next     = m_d_reg;
        m_st_next    = m_st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        div_req.start = 1'b0;
        mul_req.start = mul_kick_reg;
        s_ready      = (state_reg == rped_pkg::S_IDLE);

        unique case (state_reg)
            rped_pkg::S_IDLE: begin
                if (s_valid) begin
                    p_next     = s_prime_p & CAND_MASK;
                    q_next     = s_prime_q & CAND_MASK;
                    e_next     = s_public_exponent;
                    n_next     = s_prime_p & CAND_MASK;
                    i_next     = 9'd2;
                    sq_next    = 17'd4;
                    which_next = 1'b0;
                    state_next = rped_pkg::S_PR_TEST;
                end
            end
            rped_pkg::S_PR_TEST: begin
                if (n_reg < CW'(2)) begin
                    res_d_next  = '0;
                    res_st_next = rped_pkg::ST_NOT_PRIME;
                    state_next  = rped_pkg::S_FIN;
                end else if (sq_reg > 17'(n_reg)) begin
                    state_next = rped_pkg::S_PR_NEXT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = rped_pkg::S_PR_DIV;
                end
            end
            rped_pkg::S_PR_DIV: begin
                if (div_rsp.done) begin
                    if (div_rem == '0) begin
                        res_d_next  = '0;
                        res_st_next = rped_pkg::ST_NOT_PRIME;
                        state_next  = rped_pkg::S_FIN;
                    end else begin
                        // (i+1)^2 = i^2 + 2i + 1
                        sq_next    = sq_reg + {7'd0, i_reg, 1'b1};
                        i_next     = i_reg + 9'd1;
                        state_next = rped_pkg::S_PR_TEST;
                    end
                end
            end
            rped_pkg::S_PR_NEXT: begin
                if (!which_reg) begin
                    which_next = 1'b1;
                    n_next     = q_reg;
                    i_next     = 9'd2;
                    sq_next    = 17'd4;
                    state_next = rped_pkg::S_PR_TEST;
                end else begin
                    state_next = rped_pkg::S_PHI;
                end
            end
            rped_pkg::S_PHI: begin
                phi_next   = W'(p_reg - CW'(1)) * W'(q_reg - CW'(1));
                state_next = rped_pkg::S_EU_INIT;
            end
            rped_pkg::S_EU_INIT: begin
                if (e_reg == '0) begin
                    res_d_next  = '0;
                    res_st_next = rped_pkg::ST_NO_INV;
                    state_next  = rped_pkg::S_FIN;
                end else begin
                    a_next     = phi_reg;
                    b_next     = e_reg;
                    c0_next    = '0;
                    // 1 mod phi: zero when phi is one
                    c1_next    = (phi_reg == W'(1)) ? '0 : W'(1);
                    state_next = rped_pkg::S_EU_GO;
                end
            end
            rped_pkg::S_EU_GO: begin
                div_req.start = 1'b1;
                state_next    = rped_pkg::S_EU_DIV;
            end
            rped_pkg::S_EU_DIV: begin
                if (div_rsp.done) begin
                    if (div_rem == '0) begin
                        if (b_reg == W'(1)) begin
                            res_d_next  = c1_reg;
                            res_st_next = rped_pkg::ST_OK;
                        end else begin
                            res_d_next  = '0;
                            res_st_next = rped_pkg::ST_NO_INV;
                        end
                        state_next = rped_pkg::S_FIN;
                    end else begin
                        quo_next   = div_quo;
                        r_next     = div_rem;
                        state_next = rped_pkg::S_EU_MUL;
                    end
                end
            end
            rped_pkg::S_EU_MUL: begin
                // first cycle here the quotient is registered and the kick starts the multiply
                if (mul_rsp.done) begin
                    c0_next    = c1_reg;
                    c1_next    = cn_wide[W-1:0];
                    a_next     = b_reg;
                    b_next     = r_reg;
                    state_next = rped_pkg::S_EU_GO;
                end
            end
            rped_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_d_next     = res_d_reg;
                    m_st_next    = res_st_reg;
                    state_next   = rped_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rped_pkg::S_IDLE;
            end
        endcase
    end

    // start flag for the multiply: high only on the first cycle in EU_MUL
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_kick_reg <= 1'b0;
        end else begin
            mul_kick_reg <= (state_reg == rped_pkg::S_EU_DIV) && div_rsp.done
                            && (div_rem != '0);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_private_exponent = m_d_reg;
    assign m_status           = m_st_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != rped_pkg::ST_OK) |-> (m_private_exponent == '0))
        else $error("nonzero exponent with failing status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 2'd3))
        else $error("reserved status code");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (state_reg == rped_pkg::S_PR_TEST))
        else $error("accepted request did not start trial division");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_rsp.done && mul_rsp.done))
        else $error("divider and multiplier finished together");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: RSA private exponent unit
// Sends p/q/e requests with random gaps, predicts d and status with a local
// trial-division plus extended Euclid model, and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 100000;   // cycles with no beat on either side
    localparam int TAIL_CYCLES = 50;

    typedef struct {
        logic [31:0]        priv_exp;
        rped_pkg::status_t  status;
    } key_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_prime_p = '0;
    logic [15:0] s_prime_q = '0;
    logic [31:0] s_public_exponent = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_private_exponent;
    logic [1:0]  m_status;

    key_result_t pending_keys[$];
    int          fail_count = 0;
    bit          send_no_idle = 1'b0;
    bit          recv_no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_len = 0;
    int          quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rsa_private_exponent_derive_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_prime_p          (s_prime_p),
        .s_prime_q          (s_prime_q),
        .s_public_exponent  (s_public_exponent),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_private_exponent (m_private_exponent),
        .m_status           (m_status)
    );

    // ---------------- prediction ----------------
    function automatic bit cand_is_prime(longint unsigned n);
        longint unsigned i;
        if (n < 2) return 1'b0;
        for (i = 2; i * i <= n; i++) begin
            if (n % i == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned mod_add(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        return (a >= m - b) ? a - (m - b) : a + b;
    endfunction

    function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 0;
        a = a % m;
        b = b % m;
        while (b != 0) begin
            if (b[0]) acc = mod_add(acc, a, m);
            a = mod_add(a, a, m);
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic key_result_t derive_key(logic [15:0] p, logic [15:0] q,
                                               logic [31:0] e);
        key_result_t     res;
        longint unsigned phi, a, b, r, quo, c0, c1, cn, prod;
        res.priv_exp = '0;
        res.status   = rped_pkg::ST_OK;
        if (!cand_is_prime(p) || !cand_is_prime(q)) begin
            res.status = rped_pkg::ST_NOT_PRIME;
            return res;
        end
        phi = (longint'(p) - 1) * (longint'(q) - 1);
        if (e == 0) begin
            res.status = rped_pkg::ST_NO_INV;
            return res;
        end
        a  = phi;
        b  = e;
        c0 = 0;
        c1 = 1 % phi;
        forever begin
            r = a % b;
            if (r == 0) break;
            quo  = a / b;
            prod = mod_mul(quo, c1, phi);
            cn   = (c0 >= prod) ? c0 - prod : c0 + (phi - prod);
            c0   = c1;
            c1   = cn;
            a    = b;
            b    = r;
        end
        if (b == 1) res.priv_exp = c1[31:0];
        else res.status = rped_pkg::ST_NO_INV;
        return res;
    endfunction

    // ---------------- input side ----------------
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_key(logic [15:0] p, logic [15:0] q, logic [31:0] e);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_prime_p         <= p;
        s_prime_q         <= q;
        s_public_exponent <= e;
        s_valid           <= 1'b1;
        do @(negedge aclk); while (!s_ready);
        pending_keys.push_back(derive_key(p, q, e));
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
    endtask

    // ---------------- output side ----------------
    // m_ready is decided at rising edges, beats are sampled at falling edges.
    initial begin : result_checker
        int          gap;
        key_result_t want;
        @(posedge aresetn);
        @(posedge aclk);
        forever begin
            gap = recv_no_idle ? 0 : $urandom_range(0, 11);
            if (hold_req) begin
                gap      = hold_len;   // long back-pressure stretch
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            if (pending_keys.size() == 0) begin
                $error("result beat with no request outstanding: d=%0d status=%0d",
                       m_private_exponent, m_status);
                fail_count++;
            end else begin
                want = pending_keys.pop_front();
                if (m_private_exponent !== want.priv_exp) begin
                    $error("private_exponent expected %0d actual %0d",
                           want.priv_exp, m_private_exponent);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_status);
                    fail_count++;
                end
            end
            @(posedge aclk);
        end
    end

    // watchdog: any beat on either channel restarts the count
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL rsa_private_exponent_derive_unit");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [15:0] pick_candidate();
        int unsigned sel, n;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            n = $urandom_range(2, 400);
            while (!cand_is_prime(n)) n++;
        end else if (sel < 63) begin
            n = $urandom_range(60000, 65000);
            while (!cand_is_prime(n)) n++;
        end else begin
            n = $urandom_range(0, 65535);
        end
        return n[15:0];
    endfunction

    function automatic logic [31:0] pick_exponent();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return ($urandom_range(1, 1000) << 1) | 1;
        if (sel < 70) return $urandom;
        if (sel < 80) return 32'd65537;
        if (sel < 95) return $urandom_range(1, 20);
        return 32'd0;
    endfunction

    task automatic test_directed();
        send_key(16'd0, 16'd7, 32'd5);           // zero candidate
        send_key(16'd11, 16'd1, 32'd3);          // one is not prime
        send_key(16'd4, 16'd13, 32'd5);          // small composite
        send_key(16'hFFFF, 16'd3, 32'd7);        // max field, composite
        send_key(16'd17, 16'd65521, 32'd3);      // small and large prime
        send_key(16'd61, 16'd53, 32'd17);        // textbook case
        send_key(16'd61, 16'd53, 32'd0);         // zero exponent
        send_key(16'd61, 16'd53, 32'd1);         // e = 1 divides phi
        send_key(16'd5, 16'd7, 32'd6);           // e divides phi
        send_key(16'd5, 16'd7, 32'd9);           // gcd 3
        send_key(16'd3, 16'd5, 32'hFFFFFFFF);    // e above phi
        send_key(16'd3, 16'd5, 32'h80000000);    // even, no inverse
        send_key(16'd2, 16'd2, 32'd7);           // unit totient
        send_key(16'd2, 16'd2, 32'hFFFFFFFF);
        send_key(16'd2, 16'd2, 32'd0);
        send_key(16'd2, 16'd3, 32'd1);
        send_key(16'd65521, 16'd65519, 32'd65537);
        send_key(16'd65521, 16'd65521, 32'hFFFFFFFF);
        send_key(16'd32749, 16'd257, 32'h55555555);
        send_key(16'd65519, 16'hFFFE, 32'hAAAAAAAA);
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_no_idle = ~send_no_idle;
                recv_no_idle = ~recv_no_idle;
            end
            send_key(pick_candidate(), pick_candidate(), pick_exponent());
        end
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
    endtask

    // receiver stalls long while requests keep coming
    task automatic test_backpressure();
        hold_len = 3000;
        hold_req = 1'b1;
        repeat (5) send_key(16'd13, 16'd17, pick_exponent());
    endtask

    // sender pauses until the unit has returned everything
    task automatic test_drain_pause();
        wait_results_drained();
        @(posedge aclk);
        send_key(16'd7, 16'd11, 32'd7);
        wait_results_drained();
        @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_drain_pause();
        test_backpressure();
        test_random(37);
        test_drain_pause();
        test_random(37);
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_keys.size() == 0) begin
            $display("PASS rsa_private_exponent_derive_unit");
        end else begin
            $display("FAIL rsa_private_exponent_derive_unit");
        end
        $finish;
    end

endmodule

// ----- rsa_private_exponent_derive_unit.f -----
rtl/rped_pkg.sv
rtl/rped_serial_div.sv
rtl/rped_serial_mulmod.sv
rtl/rsa_private_exponent_derive_unit.sv
sim/testbench.sv
